FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CWAC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("cwac assertion failed");

`define CWAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cwac assertion failed");

`else

`define CWAC_ASSERT(label, clk, rst, prop)

`define CWAC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/cwac_pkg.sv
`timescale 1ns / 1ps

package cwac_pkg;

   localparam int SUBJ_W  = 4;
   localparam int OBJ_W   = 4;
   localparam int FIRM_W  = 4;
   localparam int CLASS_W = 4;
   localparam int MASK_W  = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [FIRM_W-1:0]  NO_FIRM  = 4'd8;
   localparam logic [CLASS_W-1:0] NO_CLASS = 4'hF;

   localparam logic [63:0] OBJECT_FIRM_MAP_RESET = 64'hFFFF_FFFF_2221_1010;
   localparam logic [31:0] FIRM_CLASS_MAP_RESET  = 32'hFFFF_F100;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OBJECT_FIRM_MAP = 2'd0,
      CSR_FIRM_CLASS_MAP  = 2'd1
   } csr_index_type;

   typedef logic [MASK_W-1:0] mask_type;

endpackage

FILE: rtl/chinese_wall_access_check.sv
`timescale 1ns / 1ps
//  Channel   Direction  Handshake           Payload
//  req_      in         req_valid/req_stall req_func, req_subject_index, req_object_index
//  rsp_      out        rsp_valid/rsp_stall rsp_granted
//  csr_      in         csr_write_enable    csr_index, csr_write_data
//
// One request is taken every cycle while req_stall is low. The result register and
// the per-subject masks are loaded at the same edge, as the request leaves the
// input register, so the next request always sees the history of the one before.
// Reset clears all access history and loads the default firm and class maps.
// A stalled result holds its register, and req_stall rises while the input
// register holds a request that cannot move on.

module chinese_wall_access_check #(
   parameter int SUBJECTS = 16,
   parameter int OBJECTS  = 16,
   parameter int FIRMS    = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_func,
   input  logic [cwac_pkg::SUBJ_W-1:0]            req_subject_index,
   input  logic [cwac_pkg::OBJ_W-1:0]             req_object_index,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_granted,
   input  logic                                   csr_write_enable,
   input  logic [cwac_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cwac_pkg::CSR_DATA_W-1:0]        csr_write_data
);

`include "assert_macros.svh"

   localparam int SUBJ_SPAN = 1 << cwac_pkg::SUBJ_W;
   localparam int DEPTH     = (SUBJECTS < SUBJ_SPAN) ? SUBJECTS : SUBJ_SPAN;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MW        = cwac_pkg::MASK_W;
   localparam int CW        = cwac_pkg::CLASS_W;

   localparam logic [cwac_pkg::SUBJ_W+4:0] SUBJ_LIM = (cwac_pkg::SUBJ_W+5)'(SUBJECTS);
   localparam logic [cwac_pkg::OBJ_W:0]    OBJ_LIM  = (cwac_pkg::OBJ_W+1)'(OBJECTS);
   localparam logic [cwac_pkg::FIRM_W-1:0] FIRM_LIM = cwac_pkg::FIRM_W'(FIRMS);

   logic [63:0]                  object_firm_map_ff;
   logic [31:0]                  firm_class_map_ff;

   logic                         s1_valid_ff;
   logic [1:0]                   s1_func_ff;
   logic [cwac_pkg::SUBJ_W-1:0]  s1_subj_ff;
   logic [cwac_pkg::OBJ_W-1:0]   s1_obj_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_granted_ff;

   cwac_pkg::mask_type           acc_ff [DEPTH];
   cwac_pkg::mask_type           rd_ff  [DEPTH];
   cwac_pkg::mask_type           acc_in [DEPTH];
   cwac_pkg::mask_type           rd_in  [DEPTH];

   logic                         advance;
   logic                         xfer;
   logic                         take_req;
   logic                         grant_in;
   logic                         subj_ok;
   logic                         obj_ok;
   logic [AW-1:0]                subj_idx;
   logic [cwac_pkg::FIRM_W-1:0]  raw_firm;
   logic [cwac_pkg::FIRM_W-1:0]  obj_firm;
   logic [CW-1:0]                obj_class;
   logic [CW*MW-1:0]             class_ext;
   logic [CW-1:0]                bit_class [MW];
   cwac_pkg::mask_type           cur_acc;
   cwac_pkg::mask_type           cur_rd;
   cwac_pkg::mask_type           firm_bit;
   logic                         class_seen;
   logic                         other_read;
   logic                         read_ok;
   logic                         is_read;
   logic                         is_write;
   logic                         is_clear;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign xfer      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   assign is_read  = (s1_func_ff == cwac_pkg::FUNC_READ);
   assign is_write = (s1_func_ff == cwac_pkg::FUNC_WRITE);
   assign is_clear = (s1_func_ff == cwac_pkg::FUNC_CLEAR);

   assign subj_idx = s1_subj_ff[AW-1:0];
   assign subj_ok  = {5'd0, s1_subj_ff} < SUBJ_LIM;
   assign obj_ok   = {1'b0, s1_obj_ff} < OBJ_LIM;
   assign raw_firm = object_firm_map_ff[{s1_obj_ff, 2'b00} +: cwac_pkg::FIRM_W];
   assign obj_firm = (obj_ok && (raw_firm < FIRM_LIM)) ? raw_firm : cwac_pkg::NO_FIRM;

   // The no-firm bit sits past the last real firm and always has no class.
   assign class_ext = {cwac_pkg::NO_CLASS, firm_class_map_ff};

   always_comb begin
      for (int f = 0; f < MW; f++) begin
         if (f < FIRMS) begin
            bit_class[f] = class_ext[CW*f +: CW];
         end else begin
            bit_class[f] = cwac_pkg::NO_CLASS;
         end
      end
   end

   assign obj_class = bit_class[obj_firm];
   assign cur_acc   = acc_ff[subj_idx];
   assign cur_rd    = rd_ff[subj_idx];
   assign firm_bit  = cwac_pkg::mask_type'(1) << obj_firm;

   always_comb begin
      class_seen = 1'b0;
      other_read = 1'b0;
      for (int f = 0; f < MW; f++) begin
         if (cur_acc[f] && (bit_class[f] == obj_class)) begin
            class_seen = 1'b1;
         end
         if (cur_rd[f] && (obj_firm != cwac_pkg::FIRM_W'(f)) && (bit_class[f] == obj_class)) begin
            other_read = 1'b1;
         end
      end
   end

   assign read_ok = !class_seen || cur_acc[obj_firm];

   always_comb begin
      grant_in = 1'b0;
      if (is_clear) begin
         grant_in = 1'b1;
      end else if ((is_read || is_write) && subj_ok) begin
         grant_in = read_ok && !(is_write && other_read);
      end
   end

   always_comb begin
      for (int s = 0; s < DEPTH; s++) begin
         acc_in[s] = acc_ff[s];
         rd_in[s]  = rd_ff[s];
      end
      if (xfer) begin
         if (is_clear) begin
            for (int s = 0; s < DEPTH; s++) begin
               acc_in[s] = '0;
               rd_in[s]  = '0;
            end
         end else if (grant_in) begin
            acc_in[subj_idx] = cur_acc | firm_bit;
            if (is_read) begin
               rd_in[subj_idx] = cur_rd | firm_bit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         object_firm_map_ff <= cwac_pkg::OBJECT_FIRM_MAP_RESET;
         firm_class_map_ff  <= cwac_pkg::FIRM_CLASS_MAP_RESET;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         for (int s = 0; s < DEPTH; s++) begin
            acc_ff[s] <= '0;
            rd_ff[s]  <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               cwac_pkg::CSR_OBJECT_FIRM_MAP: object_firm_map_ff <= csr_write_data;
               cwac_pkg::CSR_FIRM_CLASS_MAP:  firm_class_map_ff  <= csr_write_data[31:0];
               default: ;
            endcase
         end
         if (take_req) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         for (int s = 0; s < DEPTH; s++) begin
            acc_ff[s] <= acc_in[s];
            rd_ff[s]  <= rd_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_func_ff <= req_func;
         s1_subj_ff <= req_subject_index;
         s1_obj_ff  <= req_object_index;
      end
      if (xfer) begin
         rsp_granted_ff <= grant_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;

   `CWAC_ASSERT(a_stall_only_when_full, clock, reset, !req_stall || s1_valid_ff)
   `CWAC_ASSERT_NEXT(a_clear_granted, clock, reset, xfer && is_clear, rsp_valid_ff && rsp_granted_ff)
   `CWAC_ASSERT_NEXT(a_read_recorded, clock, reset, xfer && is_read && grant_in, rd_ff[$past(subj_idx)][$past(obj_firm)] && acc_ff[$past(subj_idx)][$past(obj_firm)])
   `CWAC_ASSERT_NEXT(a_result_drains, clock, reset, rsp_valid_ff && !rsp_stall && !xfer, !rsp_valid_ff)

endmodule
